// ===== design/assert_macros.svh =====
// Assertion helpers shared by the rotation centre design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RCA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCA_ASSERT(lbl, clk, rst_n, prop, msg)
`define RCA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/rca_pkg.sv =====
package rca_pkg;
	localparam int COORD_W = 16;
	localparam int DIFF_W = 17;
	localparam int SQ_W = 32;
	localparam int C_W = 33;
	localparam int PW_W = 34;
	localparam int PN_W = 50;
	localparam int W_W = 35;
	localparam int N_W = 51;
	localparam int WM_W = 34;
	localparam int NM_W = 50;
	localparam int NUM_W = NM_W + 12;
	localparam int DEN_W = WM_W + 1;
	localparam int Q_W = 32;
	localparam int DIV_STEPS = Q_W;
	localparam int CEN_W = 32;
	localparam int U_W = 33;
	localparam int US_W = 25;
	localparam int SH_W = 4;
	localparam int P_W = 50;
	localparam int D_W = 51;
	localparam int CX_W = 53;
	localparam int Z_W = 19;
	localparam int AM_W = 15;
	localparam int ANG_W = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int DET_W = 40;
	localparam int CL_W = 31;
	localparam int CFG_W = 40;
	localparam int IDX_W = 2;

	localparam int FRONT_LAT = 6;
	localparam int DIV_LAT = DIV_STEPS + 1;
	localparam int VEC_LAT = 6;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + VEC_LAT + CORDIC_LAT + 1;

	localparam logic signed [Z_W-1:0] PI_HALF = Z_W'(102944);
	localparam logic [AM_W-1:0] ANGLE_MAX = AM_W'(25736);

	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_DET_MIN = 2'd0;
	localparam reg_idx_t REG_COORD_LIMIT = 2'd1;
	localparam reg_idx_t REG_ANGLE_MIN = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
		logic signed [COORD_W-1:0] x3;
		logic signed [COORD_W-1:0] y3;
	} pts_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic none_w;
		pts_t pts;
	} side_t;

	typedef struct packed {
		logic none;
		logic signed [CEN_W-1:0] cx;
		logic signed [CEN_W-1:0] cy;
	} res_t;

	function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned idx);
		case (idx)
			0: return Z_W'(51472);
			1: return Z_W'(30386);
			2: return Z_W'(16055);
			3: return Z_W'(8150);
			4: return Z_W'(4091);
			5: return Z_W'(2047);
			6: return Z_W'(1024);
			7: return Z_W'(512);
			8: return Z_W'(256);
			9: return Z_W'(128);
			10: return Z_W'(64);
			11: return Z_W'(32);
			12: return Z_W'(16);
			13: return Z_W'(8);
			14: return Z_W'(4);
			15: return Z_W'(2);
			default: return '0;
		endcase
	endfunction
endpackage

// ===== design/rca_front.sv =====
module rca_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic signed [rca_pkg::COORD_W-1:0] p1_x,
	input  logic signed [rca_pkg::COORD_W-1:0] p1_y,
	input  logic signed [rca_pkg::COORD_W-1:0] p2_x,
	input  logic signed [rca_pkg::COORD_W-1:0] p2_y,
	input  logic signed [rca_pkg::COORD_W-1:0] p3_x,
	input  logic signed [rca_pkg::COORD_W-1:0] p3_y,
	input  logic [rca_pkg::DET_W-1:0] det_min,
	output logic out_vld,
	output logic [rca_pkg::NUM_W-1:0] num_x,
	output logic [rca_pkg::NUM_W-1:0] num_y,
	output logic [rca_pkg::DEN_W-1:0] den,
	output rca_pkg::side_t side
);
	import rca_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	pts_t pts_s1, pts_s2, pts_s3, pts_s4, pts_s5;

	logic signed [DIFF_W-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [SQ_W-1:0] sq_s1 [6];

	logic signed [DIFF_W-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [C_W-1:0] c1_s2, c2_s2;

	logic signed [PW_W-1:0] pw1_s3, pw2_s3;
	logic signed [PN_W-1:0] px1_s3, px2_s3, py1_s3, py2_s3;

	logic signed [W_W-1:0] w_s4;
	logic signed [N_W-1:0] xn_s4, yn_s4;

	logic [WM_W-1:0] wm_s5;
	logic [NM_W-1:0] mx_s5, my_s5;
	logic neg_x_s5, neg_y_s5, wz_s5;

	logic [NUM_W-1:0] num_x_s6, num_y_s6;
	logic [DEN_W-1:0] den_s6;
	side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		pts_s1 <= '{x2: p2_x, y2: p2_y, x3: p3_x, y3: p3_y};
		a1_s1 <= DIFF_W'(p1_x) - DIFF_W'(p2_x);
		b1_s1 <= DIFF_W'(p1_y) - DIFF_W'(p2_y);
		a2_s1 <= DIFF_W'(p2_x) - DIFF_W'(p3_x);
		b2_s1 <= DIFF_W'(p2_y) - DIFF_W'(p3_y);
		sq_s1[0] <= SQ_W'(p1_x) * SQ_W'(p1_x);
		sq_s1[1] <= SQ_W'(p1_y) * SQ_W'(p1_y);
		sq_s1[2] <= SQ_W'(p2_x) * SQ_W'(p2_x);
		sq_s1[3] <= SQ_W'(p2_y) * SQ_W'(p2_y);
		sq_s1[4] <= SQ_W'(p3_x) * SQ_W'(p3_x);
		sq_s1[5] <= SQ_W'(p3_y) * SQ_W'(p3_y);

		pts_s2 <= pts_s1;
		a1_s2 <= a1_s1;
		b1_s2 <= b1_s1;
		a2_s2 <= a2_s1;
		b2_s2 <= b2_s1;
		c1_s2 <= C_W'(sq_s1[2]) + C_W'(sq_s1[3]) - C_W'(sq_s1[0]) - C_W'(sq_s1[1]);
		c2_s2 <= C_W'(sq_s1[4]) + C_W'(sq_s1[5]) - C_W'(sq_s1[2]) - C_W'(sq_s1[3]);

		pts_s3 <= pts_s2;
		pw1_s3 <= PW_W'(a1_s2) * PW_W'(b2_s2);
		pw2_s3 <= PW_W'(b1_s2) * PW_W'(a2_s2);
		px1_s3 <= PN_W'(b1_s2) * PN_W'(c2_s2);
		px2_s3 <= PN_W'(c1_s2) * PN_W'(b2_s2);
		py1_s3 <= PN_W'(c1_s2) * PN_W'(a2_s2);
		py2_s3 <= PN_W'(a1_s2) * PN_W'(c2_s2);

		pts_s4 <= pts_s3;
		w_s4 <= W_W'(pw1_s3) - W_W'(pw2_s3);
		xn_s4 <= N_W'(px1_s3) - N_W'(px2_s3);
		yn_s4 <= N_W'(py1_s3) - N_W'(py2_s3);

		pts_s5 <= pts_s4;
		wm_s5 <= w_s4[W_W-1] ? WM_W'(-w_s4) : WM_W'(w_s4);
		mx_s5 <= xn_s4[N_W-1] ? NM_W'(-xn_s4) : NM_W'(xn_s4);
		my_s5 <= yn_s4[N_W-1] ? NM_W'(-yn_s4) : NM_W'(yn_s4);
		neg_x_s5 <= xn_s4[N_W-1] ^ w_s4[W_W-1];
		neg_y_s5 <= yn_s4[N_W-1] ^ w_s4[W_W-1];
		wz_s5 <= (w_s4 == '0);

		num_x_s6 <= {mx_s5, 12'b0} + NUM_W'(wm_s5);
		num_y_s6 <= {my_s5, 12'b0} + NUM_W'(wm_s5);
		den_s6 <= {wm_s5, 1'b0};
		side_s6.neg_x <= neg_x_s5;
		side_s6.neg_y <= neg_y_s5;
		side_s6.none_w <= wz_s5 || (DET_W'(wm_s5) < det_min);
		side_s6.pts <= pts_s5;
	end

	assign out_vld = vld_s6;
	assign num_x = num_x_s6;
	assign num_y = num_y_s6;
	assign den = den_s6;
	assign side = side_s6;
endmodule

// ===== design/rca_div.sv =====
`include "assert_macros.svh"
module rca_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic [rca_pkg::NUM_W-1:0] num_x,
	input  logic [rca_pkg::NUM_W-1:0] num_y,
	input  logic [rca_pkg::DEN_W-1:0] den,
	input  rca_pkg::side_t side_in,
	output logic out_vld,
	output logic [rca_pkg::Q_W-1:0] q_x,
	output logic [rca_pkg::Q_W-1:0] q_y,
	output logic ovf_x,
	output logic ovf_y,
	output rca_pkg::side_t side_out
);
	import rca_pkg::*;

	localparam int R_W = DEN_W + Q_W;

	logic vld_s [DIV_STEPS+1];
	logic [R_W-1:0] rx_s [DIV_STEPS+1];
	logic [R_W-1:0] ry_s [DIV_STEPS+1];
	logic [DEN_W-1:0] den_s [DIV_STEPS+1];
	logic ovf_x_s [DIV_STEPS+1];
	logic ovf_y_s [DIV_STEPS+1];
	side_t side_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rx_s[0] <= {DEN_W'(num_x[NUM_W-1:Q_W]), num_x[Q_W-1:0]};
		ry_s[0] <= {DEN_W'(num_y[NUM_W-1:Q_W]), num_y[Q_W-1:0]};
		ovf_x_s[0] <= DEN_W'(num_x[NUM_W-1:Q_W]) >= den;
		ovf_y_s[0] <= DEN_W'(num_y[NUM_W-1:Q_W]) >= den;
		den_s[0] <= den;
		side_s[0] <= side_in;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DEN_W:0] tx, ty;
		logic gx, gy;

		assign tx = rx_s[k][R_W-1:Q_W-1];
		assign ty = ry_s[k][R_W-1:Q_W-1];
		assign gx = tx >= {1'b0, den_s[k]};
		assign gy = ty >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rx_s[k+1] <= {(gx ? DEN_W'(tx - {1'b0, den_s[k]}) : DEN_W'(tx)),
				rx_s[k][Q_W-2:0], gx};
			ry_s[k+1] <= {(gy ? DEN_W'(ty - {1'b0, den_s[k]}) : DEN_W'(ty)),
				ry_s[k][Q_W-2:0], gy};
			den_s[k+1] <= den_s[k];
			ovf_x_s[k+1] <= ovf_x_s[k];
			ovf_y_s[k+1] <= ovf_y_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld = vld_s[DIV_STEPS];
	assign q_x = rx_s[DIV_STEPS][Q_W-1:0];
	assign q_y = ry_s[DIV_STEPS][Q_W-1:0];
	assign ovf_x = ovf_x_s[DIV_STEPS];
	assign ovf_y = ovf_y_s[DIV_STEPS];
	assign side_out = side_s[DIV_STEPS];

	`RCA_ASSERT(a_div_rem_x, clk, arst_n, vld_s[DIV_STEPS] && !ovf_x_s[DIV_STEPS] |-> rx_s[DIV_STEPS][R_W-1:Q_W] < den_s[DIV_STEPS], "x remainder not below divisor")
	`RCA_ASSERT(a_div_rem_y, clk, arst_n, vld_s[DIV_STEPS] && !ovf_y_s[DIV_STEPS] |-> ry_s[DIV_STEPS][R_W-1:Q_W] < den_s[DIV_STEPS], "y remainder not below divisor")
endmodule

// ===== design/rca_vec.sv =====
module rca_vec (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic [rca_pkg::Q_W-1:0] q_x,
	input  logic [rca_pkg::Q_W-1:0] q_y,
	input  logic ovf_x,
	input  logic ovf_y,
	input  rca_pkg::side_t side,
	input  logic [rca_pkg::CL_W-1:0] coord_limit,
	output logic out_vld,
	output logic signed [rca_pkg::D_W-1:0] d,
	output logic signed [rca_pkg::D_W-1:0] cz,
	output rca_pkg::res_t res
);
	import rca_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	res_t res_s1, res_s2, res_s3, res_s4, res_s5, res_s6;
	pts_t pts_s1;
	logic signed [U_W-1:0] u_s2 [4];
	logic signed [U_W-1:0] u_s3 [4];
	logic [SH_W-1:0] sh_s3;
	logic signed [US_W-1:0] us_s4 [4];
	logic signed [P_W-1:0] p_s5 [4];
	logic signed [D_W-1:0] d_s6, cz_s6;

	logic [Q_W-1:0] mag_or;
	logic [SH_W-1:0] sh_c;

	always_comb begin
		logic [U_W-1:0] mg;
		mag_or = '0;
		for (int i = 0; i < 4; i++) begin
			mg = u_s2[i][U_W-1] ? U_W'(-u_s2[i]) : U_W'(u_s2[i]);
			mag_or = mag_or | mg[Q_W-1:0];
		end
		sh_c = '0;
		for (int b = 24; b < 32; b++) begin
			if (mag_or[b]) begin
				sh_c = SH_W'(b - 23);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		res_s1.none <= side.none_w || ovf_x || ovf_y
			|| (q_x > {1'b0, coord_limit}) || (q_y > {1'b0, coord_limit});
		res_s1.cx <= side.neg_x ? -$signed(q_x) : $signed(q_x);
		res_s1.cy <= side.neg_y ? -$signed(q_y) : $signed(q_y);
		pts_s1 <= side.pts;

		res_s2 <= res_s1;
		u_s2[0] <= $signed({{5{pts_s1.x2[COORD_W-1]}}, pts_s1.x2, 12'b0}) - U_W'(res_s1.cx);
		u_s2[1] <= $signed({{5{pts_s1.y2[COORD_W-1]}}, pts_s1.y2, 12'b0}) - U_W'(res_s1.cy);
		u_s2[2] <= $signed({{5{pts_s1.x3[COORD_W-1]}}, pts_s1.x3, 12'b0}) - U_W'(res_s1.cx);
		u_s2[3] <= $signed({{5{pts_s1.y3[COORD_W-1]}}, pts_s1.y3, 12'b0}) - U_W'(res_s1.cy);

		res_s3 <= res_s2;
		u_s3 <= u_s2;
		sh_s3 <= sh_c;

		res_s4 <= res_s3;
		for (int i = 0; i < 4; i++) begin
			us_s4[i] <= US_W'(u_s3[i] >>> sh_s3);
		end

		res_s5 <= res_s4;
		p_s5[0] <= P_W'(us_s4[0]) * P_W'(us_s4[2]);
		p_s5[1] <= P_W'(us_s4[1]) * P_W'(us_s4[3]);
		p_s5[2] <= P_W'(us_s4[0]) * P_W'(us_s4[3]);
		p_s5[3] <= P_W'(us_s4[1]) * P_W'(us_s4[2]);

		res_s6 <= res_s5;
		d_s6 <= D_W'(p_s5[0]) + D_W'(p_s5[1]);
		cz_s6 <= D_W'(p_s5[2]) - D_W'(p_s5[3]);
	end

	assign out_vld = vld_s6;
	assign d = d_s6;
	assign cz = cz_s6;
	assign res = res_s6;
endmodule

// ===== design/rca_cordic.sv =====
`include "assert_macros.svh"
module rca_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic signed [rca_pkg::D_W-1:0] d,
	input  logic signed [rca_pkg::D_W-1:0] cz,
	input  rca_pkg::res_t res_in,
	output logic out_vld,
	output logic [rca_pkg::AM_W-1:0] ang_mag,
	output logic ang_neg,
	output logic degen,
	output rca_pkg::res_t res_out
);
	import rca_pkg::*;

	logic vld_s [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] z_s [CORDIC_STEPS+1];
	logic neg_s [CORDIC_STEPS+1];
	logic deg_s [CORDIC_STEPS+1];
	res_t res_s [CORDIC_STEPS+1];

	logic vld_f;
	logic [AM_W-1:0] mag_f;
	logic neg_f, deg_f;
	res_t res_f;

	logic signed [D_W-1:0] czm;
	logic signed [CX_W-1:0] x0, y0;
	logic signed [Z_W-1:0] z0;
	logic [Z_W-1:0] zr;
	logic [AM_W-1:0] mag_c;

	always_comb begin
		czm = cz[D_W-1] ? -cz : cz;
		if (d[D_W-1]) begin
			x0 = CX_W'(czm);
			y0 = -CX_W'(d);
			z0 = PI_HALF;
		end else begin
			x0 = CX_W'(d);
			y0 = CX_W'(czm);
			z0 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			vld_f <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			vld_f <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= x0;
		y_s[0] <= y0;
		z_s[0] <= z0;
		neg_s[0] <= cz[D_W-1];
		deg_s[0] <= (d == '0) && (cz == '0);
		res_s[0] <= res_in;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
		logic signed [CX_W-1:0] xs, ys;

		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (!y_s[k][CX_W-1]) begin
				x_s[k+1] <= x_s[k] + ys;
				y_s[k+1] <= y_s[k] - xs;
				z_s[k+1] <= z_s[k] + atan_lut(k);
			end else begin
				x_s[k+1] <= x_s[k] - ys;
				y_s[k+1] <= y_s[k] + xs;
				z_s[k+1] <= z_s[k] - atan_lut(k);
			end
			neg_s[k+1] <= neg_s[k];
			deg_s[k+1] <= deg_s[k];
			res_s[k+1] <= res_s[k];
		end
	end

	always_comb begin
		logic [Z_W-1:0] zc;
		zc = z_s[CORDIC_STEPS][Z_W-1] ? '0 : Z_W'(z_s[CORDIC_STEPS]);
		zr = (zc + Z_W'(4)) >> 3;
		mag_c = (zr > Z_W'(ANGLE_MAX)) ? ANGLE_MAX : AM_W'(zr);
	end

	always_ff @(posedge clk) begin
		mag_f <= mag_c;
		neg_f <= neg_s[CORDIC_STEPS];
		deg_f <= deg_s[CORDIC_STEPS];
		res_f <= res_s[CORDIC_STEPS];
	end

	assign out_vld = vld_f;
	assign ang_mag = mag_f;
	assign ang_neg = neg_f;
	assign degen = deg_f;
	assign res_out = res_f;

	`RCA_ASSERT_ALWAYS(a_cordic_first_quadrant, clk, vld_s[0] |-> !x_s[0][CX_W-1] && !y_s[0][CX_W-1], "vector not folded into first quadrant")
	`RCA_ASSERT(a_cordic_mag_range, clk, arst_n, vld_f |-> mag_f <= ANGLE_MAX, "angle magnitude beyond pi")
endmodule

// ===== design/rotation_center_and_angle_core.sv =====
// channel   direction  transaction strobe   payload
// start     in         start && !busy       p1_x p1_y p2_x p2_y p3_x p3_y
// result    out        done                 center_x center_y turn_angle no_center
// config    in         cfg_we               cfg_idx cfg_wdata
//
// One triple enters per cycle while busy is low; each result passes, in start order,
// through the 32-stage divider and the 16-stage CORDIC in the pipeline.
// busy is high only during reset and the first cycle after it.
// done is high for a single cycle per result; results are never held back.
// Reset clears the pipeline valid bits and loads the register defaults.
`include "assert_macros.svh"
module rotation_center_and_angle_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [rca_pkg::COORD_W-1:0] p1_x,
	input  logic signed [rca_pkg::COORD_W-1:0] p1_y,
	input  logic signed [rca_pkg::COORD_W-1:0] p2_x,
	input  logic signed [rca_pkg::COORD_W-1:0] p2_y,
	input  logic signed [rca_pkg::COORD_W-1:0] p3_x,
	input  logic signed [rca_pkg::COORD_W-1:0] p3_y,
	output logic done,
	output logic signed [rca_pkg::CEN_W-1:0] center_x,
	output logic signed [rca_pkg::CEN_W-1:0] center_y,
	output logic signed [rca_pkg::ANG_W-1:0] turn_angle,
	output logic no_center,
	input  logic cfg_we,
	input  rca_pkg::reg_idx_t cfg_idx,
	input  logic [rca_pkg::CFG_W-1:0] cfg_wdata
);
	import rca_pkg::*;

	logic ready_q;
	logic [DET_W-1:0] det_min_q;
	logic [CL_W-1:0] coord_limit_q;
	logic [AM_W-1:0] angle_min_q;
	logic acc;

	logic fr_vld, dv_vld, vc_vld, co_vld;
	logic [NUM_W-1:0] num_x, num_y;
	logic [DEN_W-1:0] den;
	side_t fr_side, dv_side;
	logic [Q_W-1:0] q_x, q_y;
	logic ovf_x, ovf_y;
	logic signed [D_W-1:0] d, cz;
	res_t vc_res, co_res;
	logic [AM_W-1:0] ang_mag;
	logic ang_neg, degen;

	logic done_q, no_center_q;
	logic signed [CEN_W-1:0] center_x_q, center_y_q;
	logic signed [ANG_W-1:0] turn_angle_q;

	assign acc = start && ready_q;
	assign busy = !ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			det_min_q <= DET_W'(1);
			coord_limit_q <= CL_W'(1073741824);
			angle_min_q <= AM_W'(1);
		end else begin
			ready_q <= 1'b1;
			if (cfg_we) begin
				case (cfg_idx)
					REG_DET_MIN: det_min_q <= cfg_wdata[DET_W-1:0];
					REG_COORD_LIMIT: coord_limit_q <= cfg_wdata[CL_W-1:0];
					REG_ANGLE_MIN: angle_min_q <= cfg_wdata[AM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	rca_front u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(acc),
		.p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
		.det_min(det_min_q), .out_vld(fr_vld),
		.num_x(num_x), .num_y(num_y), .den(den), .side(fr_side)
	);

	rca_div u_div (
		.clk(clk), .arst_n(arst_n), .in_vld(fr_vld),
		.num_x(num_x), .num_y(num_y), .den(den), .side_in(fr_side),
		.out_vld(dv_vld), .q_x(q_x), .q_y(q_y), .ovf_x(ovf_x), .ovf_y(ovf_y),
		.side_out(dv_side)
	);

	rca_vec u_vec (
		.clk(clk), .arst_n(arst_n), .in_vld(dv_vld),
		.q_x(q_x), .q_y(q_y), .ovf_x(ovf_x), .ovf_y(ovf_y), .side(dv_side),
		.coord_limit(coord_limit_q), .out_vld(vc_vld), .d(d), .cz(cz), .res(vc_res)
	);

	rca_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .in_vld(vc_vld), .d(d), .cz(cz), .res_in(vc_res),
		.out_vld(co_vld), .ang_mag(ang_mag), .ang_neg(ang_neg), .degen(degen),
		.res_out(co_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= co_vld;
		end
	end

	always_ff @(posedge clk) begin
		no_center_q <= co_res.none;
		if (co_res.none) begin
			center_x_q <= $signed({1'b0, coord_limit_q});
			center_y_q <= $signed({1'b0, coord_limit_q});
		end else begin
			center_x_q <= co_res.cx;
			center_y_q <= co_res.cy;
		end
		if (co_res.none || degen || (ang_mag < angle_min_q)) begin
			turn_angle_q <= '0;
		end else if (ang_neg) begin
			turn_angle_q <= -$signed(ANG_W'(ang_mag));
		end else begin
			turn_angle_q <= $signed(ANG_W'(ang_mag));
		end
	end

	assign done = done_q;
	assign no_center = no_center_q;
	assign center_x = center_x_q;
	assign center_y = center_y_q;
	assign turn_angle = turn_angle_q;

	`RCA_ASSERT(a_top_latency, clk, arst_n, done |-> $past(acc, TOTAL_LAT), "result without an accepted start")
	`RCA_ASSERT(a_top_no_loss, clk, arst_n, $past(acc, TOTAL_LAT) |-> done, "accepted start without a result")
	`RCA_ASSERT(a_top_no_center, clk, arst_n, done && no_center |-> turn_angle == '0 && center_x == $signed({1'b0, coord_limit_q}) && center_y == $signed({1'b0, coord_limit_q}), "no-centre result malformed")
	`RCA_ASSERT(a_top_angle_range, clk, arst_n, done |-> turn_angle <= $signed(ANG_W'(ANGLE_MAX)) && turn_angle >= -$signed(ANG_W'(ANGLE_MAX)), "turn angle beyond pi")
endmodule

// ===== dv/rotation_center_and_angle_core_tb.sv =====
module rotation_center_and_angle_core_tb;
	import rca_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	typedef struct packed {
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
		logic signed [COORD_W-1:0] x3;
		logic signed [COORD_W-1:0] y3;
	} triple_t;

	typedef struct packed {
		logic signed [CEN_W-1:0] cx;
		logic signed [CEN_W-1:0] cy;
		logic signed [ANG_W-1:0] ang;
		logic none;
	} centre_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
	logic done;
	logic signed [CEN_W-1:0] center_x, center_y;
	logic signed [ANG_W-1:0] turn_angle;
	logic no_center;
	logic cfg_we;
	reg_idx_t cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	longint unsigned det_min_q;
	longint unsigned coord_limit_q;
	longint unsigned angle_min_q;

	centre_t expected_centres[$];
	int mismatches = 0;
	int idle_cycles = 0;

	rotation_center_and_angle_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
		.done(done), .center_x(center_x), .center_y(center_y),
		.turn_angle(turn_angle), .no_center(no_center),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint turn_of(input longint d, input longint cz);
		longint x, y, z, q, xs, ys, t;
		x = d;
		y = cz < 0 ? -cz : cz;
		z = 0;
		if (d == 0 && cz == 0)
			return 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = 102944;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += ATAN_Q16[i];
			end else begin
				x -= ys;
				y += xs;
				z -= ATAN_Q16[i];
			end
		end
		if (z < 0)
			z = 0;
		q = (z + 4) >>> 3;
		if (q > 25736)
			q = 25736;
		if (cz < 0)
			q = -q;
		if (magnitude(q) < angle_min_q)
			q = 0;
		return q;
	endfunction

	function automatic centre_t predict_centre(input triple_t t);
		longint x1, y1, x2, y2, x3, y3, a1, b1, a2, b2, c1, c2, w, xn, yn, cx, cy, d, cz;
		longint u[4];
		longint unsigned wm, qx, qy, m;
		int s;
		centre_t r;
		x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2; x3 = t.x3; y3 = t.y3;
		a1 = x1 - x2; b1 = y1 - y2; a2 = x2 - x3; b2 = y2 - y3;
		c1 = x2 * x2 + y2 * y2 - x1 * x1 - y1 * y1;
		c2 = x3 * x3 + y3 * y3 - x2 * x2 - y2 * y2;
		w = a1 * b2 - b1 * a2;
		xn = b1 * c2 - c1 * b2;
		yn = c1 * a2 - a1 * c2;
		wm = magnitude(w);
		r.cx = CEN_W'(coord_limit_q);
		r.cy = CEN_W'(coord_limit_q);
		r.ang = '0;
		r.none = 1'b1;
		if (w == 0 || wm < det_min_q)
			return r;
		qx = ((magnitude(xn) << 12) + wm) / (wm << 1);
		qy = ((magnitude(yn) << 12) + wm) / (wm << 1);
		if (qx > coord_limit_q || qy > coord_limit_q)
			return r;
		cx = ((xn < 0) != (w < 0)) ? -longint'(qx) : longint'(qx);
		cy = ((yn < 0) != (w < 0)) ? -longint'(qy) : longint'(qy);
		u[0] = x2 * 4096 - cx;
		u[1] = y2 * 4096 - cy;
		u[2] = x3 * 4096 - cx;
		u[3] = y3 * 4096 - cy;
		m = magnitude(u[0]) | magnitude(u[1]) | magnitude(u[2]) | magnitude(u[3]);
		s = 0;
		while ((m >> s) >= (64'd1 << 24))
			s++;
		for (int i = 0; i < 4; i++)
			u[i] = u[i] >>> s;
		d = u[0] * u[2] + u[1] * u[3];
		cz = u[0] * u[3] - u[1] * u[2];
		r.cx = CEN_W'(cx);
		r.cy = CEN_W'(cy);
		r.ang = ANG_W'(turn_of(d, cz));
		r.none = 1'b0;
		return r;
	endfunction

	always @(posedge clk) begin
		centre_t e;
		if (done) begin
			if (expected_centres.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: cx=%0d cy=%0d ang=%0d none=%0b",
						center_x, center_y, turn_angle, no_center);
			end else begin
				e = expected_centres.pop_front();
				if (e.cx !== center_x || e.cy !== center_y || e.ang !== turn_angle
						|| e.none !== no_center) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp cx=%0d cy=%0d ang=%0d none=%0b, got cx=%0d cy=%0d ang=%0d none=%0b",
							e.cx, e.cy, e.ang, e.none,
							center_x, center_y, turn_angle, no_center);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** rotation_center_and_angle_core: FAILED **");
			$finish;
		end
	end

	task automatic send_triple(input triple_t t);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		p1_x <= t.x1; p1_y <= t.y1; p2_x <= t.x2; p2_y <= t.y2; p3_x <= t.x3; p3_y <= t.y3;
		do
			@(posedge clk);
		while (busy);
		expected_centres.push_back(predict_centre(t));
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (expected_centres.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DET_MIN: det_min_q = val[DET_W-1:0];
			REG_COORD_LIMIT: coord_limit_q = val[CL_W-1:0];
			REG_ANGLE_MIN: angle_min_q = val[AM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic triple_t make_triple(input int x1, y1, x2, y2, x3, y3);
		triple_t t;
		t.x1 = COORD_W'(x1); t.y1 = COORD_W'(y1); t.x2 = COORD_W'(x2);
		t.y2 = COORD_W'(y2); t.x3 = COORD_W'(x3); t.y3 = COORD_W'(y3);
		return t;
	endfunction

	function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] p,
			input int span);
		int v;
		v = int'(p) + $urandom_range(0, 2 * span) - span;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return COORD_W'(v);
	endfunction

	function automatic triple_t random_triple;
		triple_t t;
		int span;
		t = {$urandom, $urandom, $urandom};
		case ($urandom_range(0, 3))
			0: ;
			1, 2: begin
				span = 1 << $urandom_range(1, 12);
				t.x2 = near(t.x1, span); t.y2 = near(t.y1, span);
				t.x3 = near(t.x2, span); t.y3 = near(t.y2, span);
			end
			default: begin
				t.x2 = near(t.x1, 4); t.y2 = near(t.y1, 4);
				t.x3 = near(t.x2, 4); t.y3 = near(t.y2, 4);
			end
		endcase
		return t;
	endfunction

	task automatic test_directed;
		send_triple(make_triple(0, 0, 0, 0, 0, 0));
		send_triple(make_triple(160, 0, 0, 160, -160, 0));
		send_triple(make_triple(-160, 0, 0, 160, 160, 0));
		send_triple(make_triple(0, 16, 16, 0, -16, 0));
		send_triple(make_triple(0, 16, -16, 0, 16, 0));
		send_triple(make_triple(5, 5, 5, 5, 40, -7));
		send_triple(make_triple(0, 0, 16, 16, 32, 32));
		send_triple(make_triple(0, 0, 16, 16, 32, 33));
		send_triple(make_triple(32767, 32767, -32768, -32768, 32767, -32768));
		send_triple(make_triple(-32768, 32767, 32767, -32768, -32768, -32768));
		send_triple(make_triple(-32768, -32768, -32768, 32767, 32767, 32767));
		send_triple(make_triple(32767, 0, 0, 32767, -32768, 0));
		send_triple(make_triple(0, 0, 1, 0, 1, 1));
		send_triple(make_triple(1000, 1000, 1001, 1000, 1002, 1001));
		send_triple(make_triple(16000, 0, 15999, 200, 15996, 400));
		send_triple(make_triple(-32768, 0, 0, -32768, 32767, 0));
		send_triple(make_triple(100, 100, 100, 100, 100, 100));
		send_triple(make_triple(-1, -1, 0, 0, 1, -1));
		drain();
	endtask

	task automatic test_register_extremes;
		logic [CFG_W-1:0] settings [7][3];
		settings = '{
			'{0, 1073741824, 0},
			'{40'hFF_FFFF_FFFF, 1073741824, 1},
			'{1, 0, 1},
			'{0, 31'h7FFF_FFFF, 25736},
			'{1000, 31'h7FFF_FFFF, 25736},
			'{200, 4096, 100},
			'{40'hFF_FFFF_FFFF, 31'h7FFF_FFFF, 15'h7FFF}};
		foreach (settings[k]) begin
			write_reg(REG_DET_MIN, settings[k][0]);
			write_reg(REG_COORD_LIMIT, settings[k][1]);
			write_reg(REG_ANGLE_MIN, settings[k][2]);
			write_reg(reg_idx_t'(3), CFG_W'({$urandom, $urandom}));
			repeat (30) send_triple(random_triple());
			drain();
		end
	endtask

	task automatic test_random_settings;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_DET_MIN, CFG_W'($urandom_range(0, 1) ? 64'($urandom_range(0, 4000))
				: {$urandom, $urandom}));
			write_reg(REG_COORD_LIMIT, CFG_W'($urandom_range(0, 1)
				? 64'(32'h4000_0000 >> $urandom_range(0, 14)) : {$urandom, $urandom}));
			write_reg(REG_ANGLE_MIN, CFG_W'($urandom_range(0, 2) == 0 ? $urandom_range(0, 25736)
				: $urandom_range(0, 64)));
			repeat (270) send_triple(random_triple());
			drain();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_DET_MIN;
		cfg_wdata <= '0;
		p1_x <= '0; p1_y <= '0; p2_x <= '0; p2_y <= '0; p3_x <= '0; p3_y <= '0;
		det_min_q = 1;
		coord_limit_q = 64'd1073741824;
		angle_min_q = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_settings();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_centres.size() == 0)
			$display("** rotation_center_and_angle_core: PASSED **");
		else
			$display("** rotation_center_and_angle_core: FAILED **");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+design
design/rca_pkg.sv
design/rca_front.sv
design/rca_div.sv
design/rca_vec.sv
design/rca_cordic.sv
design/rotation_center_and_angle_core.sv
dv/rotation_center_and_angle_core_tb.sv
